FILE: rtl/crcse_pkg.sv
package crcse_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_W     = 32;
  localparam int unsigned MAX_LANES = 8;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

  // Advances a reflected CRC-32C value through a number of all-zero bytes.
  // This is used only with constant arguments, to build the columns of the
  // XOR matrices.
  function automatic logic [CRC_W-1:0] crc_zero_fold(input logic [CRC_W-1:0] c,
                                                     input int unsigned nbytes);
    logic [CRC_W-1:0] v;
    v = c;
    for (int i = 0; i < int'(BYTE_W * (MAX_LANES + 1)); i++) begin
      if (i < int'(BYTE_W * nbytes)) begin
        v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
    end
    return v;
  endfunction

endpackage

FILE: rtl/crcse_lane.sv
module crcse_lane
  import crcse_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  logic [BYTE_W-1:0] byte_in,
  output logic [CRC_W-1:0]  contrib
);

  logic [CRC_W-1:0] term [BYTE_W];

  // The byte is folded into a zero CRC and then carried through the bytes
  // that follow it in the beat.
  for (genvar b = 0; b < int'(BYTE_W); b++) begin : g_col
    localparam logic [CRC_W-1:0] COL = crc_zero_fold(CRC_W'(1) << b, SHIFT + 1);
    assign term[b] = byte_in[b] ? COL : '0;
  end

  always_comb begin
    contrib = '0;
    for (int b = 0; b < int'(BYTE_W); b++) begin
      contrib = contrib ^ term[b];
    end
  end

endmodule

FILE: rtl/crcse_fold.sv
module crcse_fold
  import crcse_pkg::*;
#(
  parameter int unsigned LANES = 8,
  parameter int unsigned CW    = $clog2(LANES + 1)
) (
  input  logic [CRC_W-1:0] crc_in,
  input  logic [CW-1:0]    count,
  input  logic [CRC_W-1:0] contrib,
  output logic [CRC_W-1:0] crc_out
);

  logic [CRC_W-1:0] term [LANES+1][CRC_W];
  logic [CRC_W-1:0] prod [LANES+1];
  logic [CRC_W-1:0] sel;

  // One matrix per possible byte count advances the running CRC.
  for (genvar n = 0; n <= int'(LANES); n++) begin : g_cnt
    for (genvar b = 0; b < int'(CRC_W); b++) begin : g_col
      localparam logic [CRC_W-1:0] COL = crc_zero_fold(CRC_W'(1) << b, n);
      assign term[n][b] = crc_in[b] ? COL : '0;
    end
  end

  always_comb begin
    for (int n = 0; n <= int'(LANES); n++) begin
      prod[n] = '0;
      for (int b = 0; b < int'(CRC_W); b++) begin
        prod[n] = prod[n] ^ term[n][b];
      end
    end
  end

  always_comb begin
    sel = crc_in;
    for (int n = 0; n <= int'(LANES); n++) begin
      if (count == CW'(n)) begin
        sel = prod[n];
      end
    end
    crc_out = sel ^ contrib;
  end

endmodule

FILE: rtl/crc32c_stream_engine.sv
// Output: a result is shown from the second register stage after the last beat of a message
// is accepted, and is held there while out_stall is high.
// Throughput: one beat per cycle unless stalled; the running CRC register closes a loop
// through the count-selected XOR matrix, and the lane contributions are computed a stage ahead.
// Reset: synchronous, active low; clears both pipeline valids and sets the running CRC
// to all ones.
module crc32c_stream_engine
  import crcse_pkg::*;
#(
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_bytes,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_crc_value
);

  localparam int unsigned LANES = BYTES_PER_ITEM;
  localparam int unsigned CW    = $clog2(LANES + 1);

  logic              adv;
  logic [CW-1:0]     in_cnt;
  logic [BYTE_W-1:0] lane_byte    [LANES];
  logic [CRC_W-1:0]  lane_contrib [LANES];
  logic [CRC_W-1:0]  merged;

  logic              b_valid_r;
  logic              b_last_r;
  logic [CW-1:0]     b_cnt_r;
  logic [CRC_W-1:0]  b_contrib_r;
  logic [CRC_W-1:0]  crc_r;
  logic [CRC_W-1:0]  crc_nxt;
  logic              out_valid_r;
  logic [CRC_W-1:0]  out_crc_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    if (in_valid_bytes > 4'(LANES)) begin
      in_cnt = CW'(LANES);
    end else begin
      in_cnt = in_valid_bytes[CW-1:0];
    end
  end

  // The valid bytes are moved to the top lanes so that each lane has a fixed
  // number of following bytes; the empty low lanes contribute nothing.
  always_comb begin
    for (int j = 0; j < int'(LANES); j++) begin
      lane_byte[j] = '0;
      for (int m = 0; m < int'(LANES); m++) begin
        if (m <= j && in_cnt == CW'(int'(LANES) - j + m)) begin
          lane_byte[j] = in_data_bytes[BYTE_W*m +: BYTE_W];
        end
      end
    end
  end

  for (genvar j = 0; j < int'(LANES); j++) begin : g_lane
    crcse_lane #(
      .SHIFT(LANES - 1 - j)
    ) u_lane (
      .byte_in (lane_byte[j]),
      .contrib (lane_contrib[j])
    );
  end

  always_comb begin
    merged = '0;
    for (int j = 0; j < int'(LANES); j++) begin
      merged = merged ^ lane_contrib[j];
    end
  end

  crcse_fold #(
    .LANES (LANES),
    .CW    (CW)
  ) u_fold (
    .crc_in  (crc_r),
    .count   (b_cnt_r),
    .contrib (b_contrib_r),
    .crc_out (crc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= CRC_ONES;
    end else if (adv) begin
      b_valid_r   <= in_valid;
      out_valid_r <= b_valid_r && b_last_r;
      if (b_valid_r) begin
        crc_r <= b_last_r ? CRC_ONES : crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_last_r    <= in_last;
      b_cnt_r     <= in_cnt;
      b_contrib_r <= merged;
      out_crc_r   <= crc_nxt ^ CRC_ONES;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

endmodule

FILE: dv/crc32c_stream_engine_tb.sv
module crc32c_stream_engine_tb;
  import crcse_pkg::*;

  localparam int unsigned LANES       = 8;
  localparam int unsigned RANDOM_BEATS = 1000;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          N_DIRECTED  = 21;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic        pinned;
    logic [31:0] want;
    logic        drain;
  } msg_beat_t;

  // Rows with pinned set carry a known CRC-32C check value; the others rely on the predictor.
  localparam msg_beat_t DIRECTED [N_DIRECTED] = '{
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{64'h3837_3635_3433_3231, 4'd8,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'hFFFF_FFFF_FFFF_FF39, 4'd1,  1'b1, 1'b1, 32'hE306_9283, 1'b0},
    '{64'h0000_0000_0000_0000, 4'd8,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'h0000_0000_0000_0000, 4'd8,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'h0000_0000_0000_0000, 4'd8,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'h0000_0000_0000_0000, 4'd8,  1'b1, 1'b1, 32'h8A91_36AA, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd9,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, 32'h0,         1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 1'b0, 1'b0, 32'h0,         1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1, 1'b1, 32'h62A8_AB43, 1'b0},
    '{64'h0123_4567_89AB_CDEF, 4'd0,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'h0123_4567_89AB_CDEF, 4'd1,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'hFEDC_BA98_7654_3210, 4'd2,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'hA5A5_5A5A_C3C3_3C3C, 4'd3,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'h8000_0000_0000_0001, 4'd4,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'h1357_9BDF_2468_ACE0, 4'd5,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'hF0F0_0F0F_FF00_00FF, 4'd6,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'h7FFF_FFFF_FFFF_FFFE, 4'd7,  1'b0, 1'b0, 32'h0,         1'b0},
    '{64'hDEAD_BEEF_CAFE_F00D, 4'd0,  1'b1, 1'b0, 32'h0,         1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1, 1'b0, 32'h0,         1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_data_bytes = '0;
  logic [3:0]  in_valid_bytes = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_crc_value;

  msg_beat_t   beats[$];
  logic [31:0] crc_due[$];
  logic [31:0] msg_crc = CRC_ONES;
  int          send_idx = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  crc32c_stream_engine #(
    .BYTES_PER_ITEM(LANES)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_bytes (in_data_bytes),
    .in_valid_bytes(in_valid_bytes),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] crc_after_beat(input logic [31:0] crc,
                                                 input logic [63:0] data,
                                                 input logic [3:0]  nbytes);
    logic [31:0] c;
    int unsigned n;
    c = crc;
    n = (nbytes > LANES) ? LANES : nbytes;
    for (int i = 0; i < int'(LANES); i++) begin
      if (i < int'(n)) begin
        c = c ^ {24'h0, data[8*i +: 8]};
        for (int b = 0; b < 8; b++) begin
          c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
      end
    end
    return c;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch: %s got %08h want %08h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin : traffic
    logic [31:0] folded;
    logic [31:0] want;
    bit          calm;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (crc_due.size() == 0) begin
          note_mismatch("crc_value with none expected", out_crc_value, 32'h0);
        end else begin
          want = crc_due.pop_front();
          if (out_crc_value !== want) begin
            note_mismatch("crc_value", out_crc_value, want);
          end
        end
      end
      if (in_valid && !in_stall) begin
        folded = crc_after_beat(msg_crc, in_data_bytes, in_valid_bytes);
        if (in_last) begin
          crc_due.push_back(beats[send_idx].pinned ? beats[send_idx].want : (folded ^ CRC_ONES));
          msg_crc = CRC_ONES;
        end else begin
          msg_crc = folded;
        end
        send_idx++;
      end
      // A long window mid-run offers beats without random gaps and never stalls the output.
      calm = (send_idx >= 400) && (send_idx < 650);
      if (!in_valid || !in_stall) begin
        if (send_idx < beats.size() && !(beats[send_idx].drain && crc_due.size() != 0) &&
            (calm || $urandom_range(99) >= 24)) begin
          in_data_bytes  <= beats[send_idx].data;
          in_valid_bytes <= beats[send_idx].nbytes;
          in_last        <= beats[send_idx].last;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 24);
    end
  end

  initial begin
    msg_beat_t b;
    int unsigned len;
    for (int i = 0; i < N_DIRECTED; i++) begin
      beats.push_back(DIRECTED[i]);
    end
    while (beats.size() < N_DIRECTED + RANDOM_BEATS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      for (int k = 0; k < int'(len); k++) begin
        b.data   = {$urandom, $urandom};
        b.nbytes = ($urandom_range(9) < 7) ? 4'd8 : 4'($urandom_range(15));
        b.last   = (k == int'(len) - 1);
        b.pinned = 1'b0;
        b.want   = '0;
        b.drain  = (k == 0) && (beats.size() == N_DIRECTED || $urandom_range(39) == 0);
        beats.push_back(b);
      end
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (!(send_idx == beats.size() && crc_due.size() == 0)) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/crcse_pkg.sv
rtl/crcse_lane.sv
rtl/crcse_fold.sv
rtl/crc32c_stream_engine.sv
dv/crc32c_stream_engine_tb.sv
